/* rtl/pfot_pkg.sv */
// ----------------------------------------------------------------------------
// pfot_pkg
// types, constants and the topology function of the fast-or topology trigger
// ----------------------------------------------------------------------------
package pfot_pkg;

  localparam int CHIPS_PER_GROUP = 20;
  localparam int INNER_SECTORS   = 20;
  localparam int OUTER_SECTORS   = 40;
  localparam int ALL_SECTORS     = INNER_SECTORS + OUTER_SECTORS;
  localparam int INNER_MAX       = 400;
  localparam int OUTER_MAX       = 800;
  localparam int TERM_ROWS       = 10;
  localparam int TERM_COLS       = 2;
  localparam int MIN_COUNT       = 2;

  localparam int GROUP_W = 6;
  localparam int FIRED_W = $clog2(CHIPS_PER_GROUP + 1);
  localparam int INNER_W = 9;
  localparam int OUTER_W = 10;
  localparam int ADDR_W  = 3;

  localparam logic REG_CCUP9_SEL = 1'b0;

  typedef struct packed {
    logic [GROUP_W-1:0]         group_index;
    logic [CHIPS_PER_GROUP-1:0] chip_bits;
    logic                       last;
    logic                       veto_a_fired;
    logic                       veto_c_fired;
    logic                       diff_a_fired;
    logic                       diff_c_fired;
  } in_t;

  typedef struct packed {
    logic               topology_fired;
    logic               any_hit;
    logic               outer_two;
    logic               both_two;
    logic               event_accept;
    logic [INNER_W-1:0] inner_total;
    logic [OUTER_W-1:0] outer_total;
  } out_t;

  typedef struct packed {
    logic               is_inner;
    logic               is_outer;
    logic               has_hit;
    logic [GROUP_W-1:0] sector;
    logic [FIRED_W-1:0] fired;
    logic               last;
    logic               veto;
  } cls_t;

  function automatic logic topology(input logic [INNER_SECTORS-1:0] inner,
                                    input logic [OUTER_SECTORS-1:0] outer);
    logic hit;
    logic o1;
    logic o2;
    logic i1;
    logic i2;
    int   k;
    hit = 1'b0;
    for (int i = 0; i < TERM_ROWS; i++) begin
      for (int j = 0; j < TERM_COLS; j++) begin
        k  = 2 * i + j;
        o1 = outer[k] | outer[k + 1] | outer[k + 2];
        o2 = outer[k + 20] | outer[(k + 21) % OUTER_SECTORS] |
             outer[(k + 22) % OUTER_SECTORS];
        i1 = inner[i] | inner[i + 1];
        i2 = inner[i + 10] | inner[(i + 11) % INNER_SECTORS];
        hit = hit | (o1 & o2 & i1 & i2);
      end
    end
    return hit;
  endfunction

endpackage

/* rtl/pixel_fastor_topology_trigger_core.sv */
// ----------------------------------------------------------------------------
// pixel_fastor_topology_trigger_core
// fast-or topology trigger over 20 inner and 40 outer pixel chip groups
// ----------------------------------------------------------------------------
// input words carry one chip group each and enter on push while full is low.
// a word with last set closes the event: its decision word (five flags and
// both layer counts) shows on out_data while empty is low and leaves on pop.
// the decision word is registered: the last input word passes the input
// register and the queue, then the back end folds the queue head and loads
// the result register.
// throughput: one input word per cycle while full is low, set by the back end,
// folding one queued word per cycle into sector bits and saturating counts.
// while a decision word waits unpopped, the back end holds the next last word;
// plain group words keep flowing until the queue and input register fill,
// and only then does full rise.
// the selection register sits at byte address 0 of the apb-style port and
// reads back in bit 0; it resets to 1.
// reset (synchronous, rst_n low) empties the queue and result register and
// clears all sector bits and counts.
// ----------------------------------------------------------------------------
module pixel_fastor_topology_trigger_core import pfot_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  in_t               in_data,
  output logic              empty,
  input  logic              pop,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic sel_r;
  logic sel_nxt;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cls_t q_wr_data;
  cls_t q_rd_data;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_CCUP9_SEL) ? {31'b0, sel_r} : 32'b0;

  always_comb begin
    sel_nxt = sel_r;
    if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_CCUP9_SEL) begin
      sel_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b1;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  pfot_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wr_data)
  );

  pfot_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_valid (q_valid),
    .rd_data (q_rd_data)
  );

  pfot_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .sel      (sel_r),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

/* rtl/pfot_front.sv */
// ----------------------------------------------------------------------------
// pfot_front
// takes input words, counts fired chips and sorts the group into a layer
// ----------------------------------------------------------------------------
module pfot_front import pfot_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_data,
  output logic q_push,
  input  logic q_full,
  output cls_t q_data
);

  logic valid_r;
  logic valid_nxt;
  cls_t cls_r;
  cls_t cls_nxt;
  logic in_take;

  assign q_push  = valid_r && !q_full;
  assign full    = valid_r && q_full;
  assign in_take = push && !full;
  assign q_data  = cls_r;

  always_comb begin
    logic [FIRED_W-1:0] n;
    n = '0;
    for (int b = 0; b < CHIPS_PER_GROUP; b++) begin
      n = n + FIRED_W'(in_data.chip_bits[b]);
    end
    cls_nxt.is_inner = in_data.group_index < GROUP_W'(INNER_SECTORS);
    cls_nxt.is_outer = !cls_nxt.is_inner && (in_data.group_index < GROUP_W'(ALL_SECTORS));
    cls_nxt.has_hit  = |in_data.chip_bits;
    cls_nxt.sector   = cls_nxt.is_inner ? in_data.group_index
                                        : in_data.group_index - GROUP_W'(INNER_SECTORS);
    cls_nxt.fired    = n;
    cls_nxt.last     = in_data.last;
    cls_nxt.veto     = in_data.veto_a_fired | in_data.veto_c_fired |
                       in_data.diff_a_fired | in_data.diff_c_fired;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_take) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

/* rtl/pfot_queue.sv */
// ----------------------------------------------------------------------------
// pfot_queue
// short first-in first-out queue of classified words between front and back
// ----------------------------------------------------------------------------
module pfot_queue import pfot_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cls_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output logic q_valid,
  output cls_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign q_full  = cnt_r == CNT_W'(DEPTH);
  assign q_valid = cnt_r != '0;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/pfot_back.sv */
// ----------------------------------------------------------------------------
// pfot_back
// folds classified words into sector bits and counts, decides on last word
// ----------------------------------------------------------------------------
module pfot_back import pfot_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cls_t q_data,
  output logic q_pop,
  input  logic sel,
  output logic empty,
  input  logic pop,
  output out_t out_data
);

  logic [INNER_SECTORS-1:0] inner_hit_r;
  logic [INNER_SECTORS-1:0] inner_hit_nxt;
  logic [OUTER_SECTORS-1:0] outer_hit_r;
  logic [OUTER_SECTORS-1:0] outer_hit_nxt;
  logic [INNER_W-1:0]       inner_cnt_r;
  logic [INNER_W-1:0]       inner_cnt_nxt;
  logic [OUTER_W-1:0]       outer_cnt_r;
  logic [OUTER_W-1:0]       outer_cnt_nxt;
  logic                     res_valid_r;
  logic                     res_valid_nxt;
  out_t                     res_r;
  out_t                     res_nxt;
  logic                     take;

  assign take     = q_valid && (!q_data.last || !res_valid_r || pop);
  assign q_pop    = take;
  assign empty    = !res_valid_r;
  assign out_data = res_r;

  // fold the word into the event state
  always_comb begin
    logic [INNER_W:0] isum;
    logic [OUTER_W:0] osum;
    for (int s = 0; s < INNER_SECTORS; s++) begin
      inner_hit_nxt[s] = inner_hit_r[s] | (q_data.is_inner && q_data.has_hit &&
                                           q_data.sector == GROUP_W'(s));
    end
    for (int s = 0; s < OUTER_SECTORS; s++) begin
      outer_hit_nxt[s] = outer_hit_r[s] | (q_data.is_outer && q_data.has_hit &&
                                           q_data.sector == GROUP_W'(s));
    end
    isum = {1'b0, inner_cnt_r} + (INNER_W + 1)'(q_data.fired);
    osum = {1'b0, outer_cnt_r} + (OUTER_W + 1)'(q_data.fired);
    inner_cnt_nxt = inner_cnt_r;
    outer_cnt_nxt = outer_cnt_r;
    if (q_data.is_inner) begin
      inner_cnt_nxt = (isum > (INNER_W + 1)'(INNER_MAX)) ? INNER_W'(INNER_MAX)
                                                         : isum[INNER_W-1:0];
    end
    if (q_data.is_outer) begin
      outer_cnt_nxt = (osum > (OUTER_W + 1)'(OUTER_MAX)) ? OUTER_W'(OUTER_MAX)
                                                         : osum[OUTER_W-1:0];
    end
  end

  // decision on the folded state
  always_comb begin
    res_nxt.topology_fired = topology(inner_hit_nxt, outer_hit_nxt);
    res_nxt.any_hit        = (inner_cnt_nxt != '0) || (outer_cnt_nxt != '0);
    res_nxt.outer_two      = outer_cnt_nxt >= OUTER_W'(MIN_COUNT);
    res_nxt.both_two       = (inner_cnt_nxt >= INNER_W'(MIN_COUNT)) &&
                             (outer_cnt_nxt >= OUTER_W'(MIN_COUNT));
    res_nxt.event_accept   = sel && !q_data.veto && res_nxt.topology_fired;
    res_nxt.inner_total    = inner_cnt_nxt;
    res_nxt.outer_total    = outer_cnt_nxt;
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (take && q_data.last) begin
      res_valid_nxt = 1'b1;
    end else if (pop) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_hit_r <= '0;
      outer_hit_r <= '0;
      inner_cnt_r <= '0;
      outer_cnt_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (take) begin
        if (q_data.last) begin
          inner_hit_r <= '0;
          outer_hit_r <= '0;
          inner_cnt_r <= '0;
          outer_cnt_r <= '0;
        end else begin
          inner_hit_r <= inner_hit_nxt;
          outer_hit_r <= outer_hit_nxt;
          inner_cnt_r <= inner_cnt_nxt;
          outer_cnt_r <= outer_cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_data.last) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* test/tb_pixel_fastor_topology_trigger_core.sv */
// ----------------------------------------------------------------------------
// tb_pixel_fastor_topology_trigger_core
// self-checking bench for the fast-or topology trigger core
// ----------------------------------------------------------------------------
// a short scripted run covers out-of-range groups, empty and full chip words,
// single-layer events, a plain coincidence, a wrap-around term and each veto
// input on its own. random events follow in four phases with the selection
// register toggled between them and different idle and stall rates on the
// two sides. most events seed one back-to-back term with random content,
// some drop a part, some are noise, and a few saturate both layer counts.
// every decision word is compared field by field to a scripted or model value.
// ----------------------------------------------------------------------------
module tb_pixel_fastor_topology_trigger_core import pfot_pkg::*; ();

  typedef struct {
    in_t  w;
    bit   typed;
    out_t want;
  } row_t;

  localparam logic [ADDR_W-1:0] SEL_ADDR = {REG_CCUP9_SEL, 2'b00};
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  in_t               in_data = '0;
  logic              empty;
  logic              pop = 1'b0;
  out_t              out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // model state
  logic [INNER_SECTORS-1:0] inner_hit;
  logic [OUTER_SECTORS-1:0] outer_hit;
  int                       inner_cnt;
  int                       outer_cnt;
  logic                     sel_q;

  out_t decisions_q[$];
  row_t script_q[$];
  in_t  burst_q[$];
  out_t oldest;

  int errors = 0;
  int n_words = 0;
  int n_decisions = 0;
  int n_topo = 0;
  int n_accept = 0;
  int n_sat = 0;
  int gap_pct = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  pixel_fastor_topology_trigger_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic b2b_coincidence(input logic [INNER_SECTORS-1:0] inn,
                                           input logic [OUTER_SECTORS-1:0] out);
    logic fired;
    int   i;
    fired = 1'b0;
    for (int k = 0; k < 2 * TERM_ROWS; k++) begin
      i = k / 2;
      fired = fired | ((|out[k +: 3]) &
              (out[(k + 20) % OUTER_SECTORS] | out[(k + 21) % OUTER_SECTORS] |
               out[(k + 22) % OUTER_SECTORS]) &
              (inn[i] | inn[i + 1]) &
              (inn[i + 10] | inn[(i + 11) % INNER_SECTORS]));
    end
    return fired;
  endfunction

  function automatic void clear_event();
    inner_hit = '0;
    outer_hit = '0;
    inner_cnt = 0;
    outer_cnt = 0;
  endfunction

  // folds one group into the event and returns 1 when a decision is due
  function automatic bit fold_group(input in_t w, output out_t res);
    int   n;
    logic topo;
    logic veto;
    n = $countones(w.chip_bits);
    res = '0;
    if (w.group_index < INNER_SECTORS) begin
      if (w.chip_bits != '0) inner_hit[w.group_index] = 1'b1;
      inner_cnt = (inner_cnt + n > INNER_MAX) ? INNER_MAX : inner_cnt + n;
    end else if (w.group_index < ALL_SECTORS) begin
      if (w.chip_bits != '0) outer_hit[w.group_index - INNER_SECTORS] = 1'b1;
      outer_cnt = (outer_cnt + n > OUTER_MAX) ? OUTER_MAX : outer_cnt + n;
    end
    if (!w.last) return 1'b0;
    topo = b2b_coincidence(inner_hit, outer_hit);
    veto = w.veto_a_fired | w.veto_c_fired | w.diff_a_fired | w.diff_c_fired;
    res.topology_fired = topo;
    res.any_hit        = (inner_cnt > 0) || (outer_cnt > 0);
    res.outer_two      = outer_cnt >= MIN_COUNT;
    res.both_two       = (inner_cnt >= MIN_COUNT) && (outer_cnt >= MIN_COUNT);
    res.event_accept   = sel_q & ~veto & topo;
    res.inner_total    = INNER_W'(inner_cnt);
    res.outer_total    = OUTER_W'(outer_cnt);
    if (inner_cnt == INNER_MAX || outer_cnt == OUTER_MAX) n_sat++;
    clear_event();
    return 1'b1;
  endfunction

  function automatic logic [CHIPS_PER_GROUP-1:0] sparse_bits();
    if ($urandom_range(1) == 0)
      return CHIPS_PER_GROUP'(1) << $urandom_range(CHIPS_PER_GROUP - 1);
    return CHIPS_PER_GROUP'($urandom) | CHIPS_PER_GROUP'(1);
  endfunction

  function automatic in_t noise_word();
    in_t w;
    w.group_index  = GROUP_W'($urandom_range(63));
    w.chip_bits    = CHIPS_PER_GROUP'($urandom);
    w.last         = 1'b0;
    w.veto_a_fired = 1'($urandom);
    w.veto_c_fired = 1'($urandom);
    w.diff_a_fired = 1'($urandom);
    w.diff_c_fired = 1'($urandom);
    return w;
  endfunction

  function automatic void add_row(input int g, input int bits, input bit lst,
                                  input logic [3:0] vetoes, input bit typed,
                                  input out_t want);
    row_t r;
    r.w.group_index = GROUP_W'(g);
    r.w.chip_bits   = CHIPS_PER_GROUP'(bits);
    r.w.last        = lst;
    {r.w.veto_a_fired, r.w.veto_c_fired, r.w.diff_a_fired, r.w.diff_c_fired} = vetoes;
    r.typed = typed;
    r.want  = want;
    script_q.insert(script_q.size(), r);
  endfunction

  task automatic check_field(input string name, input logic [31:0] e,
                             input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0d got %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // enter at a rising edge, return at the edge that takes the word
  task automatic send_word(input in_t w, input bit typed, input out_t want);
    out_t res;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    n_words++;
    if (fold_group(w, res)) begin
      decisions_q.insert(decisions_q.size(), typed ? want : res);
      n_decisions++;
      if (res.topology_fired) n_topo++;
      if (res.event_accept) n_accept++;
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (decisions_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [31:0] value,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SEL_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    rd = prdata;
    @(posedge clk);
    if (wr) sel_q = value[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_selection(input logic v);
    logic [31:0] rd;
    cfg_access(1'b1, {31'd0, v}, rd);
    cfg_access(1'b0, '0, rd);
    if (rd[0] !== sel_q) begin
      $display("%0t: selection readback expected %0d got %0d", $time, sel_q, rd[0]);
      errors++;
    end
  endtask

  task automatic build_event();
    in_t w;
    int  kind;
    int  k;
    int  drop;
    int  sec[4];
    burst_q.delete();
    kind = $urandom_range(99);
    if (kind < 2) begin
      // dense burst that runs both layer counts into saturation
      repeat ($urandom_range(21, 26)) begin
        w = noise_word();
        w.group_index = GROUP_W'($urandom_range(INNER_SECTORS - 1));
        w.chip_bits   = '1;
        burst_q.insert($urandom_range(burst_q.size()), w);
      end
      repeat ($urandom_range(41, 46)) begin
        w = noise_word();
        w.group_index = GROUP_W'(INNER_SECTORS + $urandom_range(OUTER_SECTORS - 1));
        w.chip_bits   = '1;
        burst_q.insert($urandom_range(burst_q.size()), w);
      end
    end else if (kind < 72) begin
      // one back-to-back term, sometimes with a part left out
      k = $urandom_range(2 * TERM_ROWS - 1);
      sec[0] = k / 2 + $urandom_range(1);
      sec[1] = (k / 2 + 10 + $urandom_range(1)) % INNER_SECTORS;
      sec[2] = INNER_SECTORS + k + $urandom_range(2);
      sec[3] = INNER_SECTORS + (k + 20 + $urandom_range(2)) % OUTER_SECTORS;
      drop = ($urandom_range(3) == 0) ? $urandom_range(3) : 4;
      for (int p = 0; p < 4; p++) begin
        w = noise_word();
        w.group_index = GROUP_W'(sec[p]);
        w.chip_bits   = (p == drop) ? '0 : sparse_bits();
        burst_q.insert($urandom_range(burst_q.size()), w);
      end
      repeat ($urandom_range(3)) begin
        w = noise_word();
        w.chip_bits = sparse_bits();
        burst_q.insert($urandom_range(burst_q.size()), w);
      end
    end else begin
      repeat ($urandom_range(1, 10)) burst_q.insert(burst_q.size(), noise_word());
    end
    burst_q[burst_q.size() - 1].last         = 1'b1;
    burst_q[burst_q.size() - 1].veto_a_fired = ($urandom_range(5) == 0);
    burst_q[burst_q.size() - 1].veto_c_fired = ($urandom_range(5) == 0);
    burst_q[burst_q.size() - 1].diff_a_fired = ($urandom_range(5) == 0);
    burst_q[burst_q.size() - 1].diff_c_fired = ($urandom_range(5) == 0);
  endtask

  task automatic run_events(input int quota);
    int start;
    start = n_words;
    while (n_words - start < quota) begin
      build_event();
      gap_pct = idle_pct;
      foreach (burst_q[j]) send_word(burst_q[j], 1'b0, '0);
    end
  endtask

  always @(posedge clk)
    pop <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

  always @(negedge clk) begin
    if (rst_n && pop && !empty) begin
      if (decisions_q.size() == 0) begin
        $display("%0t: unexpected decision word expected none got %p", $time, out_data);
        errors++;
      end else begin
        oldest = decisions_q.pop_front();
        check_field("topology_fired", oldest.topology_fired, out_data.topology_fired);
        check_field("any_hit", oldest.any_hit, out_data.any_hit);
        check_field("outer_two", oldest.outer_two, out_data.outer_two);
        check_field("both_two", oldest.both_two, out_data.both_two);
        check_field("event_accept", oldest.event_accept, out_data.event_accept);
        check_field("inner_total", oldest.inner_total, out_data.inner_total);
        check_field("outer_total", oldest.outer_total, out_data.outer_total);
      end
    end
  end

  initial begin
    int   idle_set[4];
    int   stall_set[4];
    logic sel_set[4];
    idle_set  = '{0, 54, 0, 21};
    stall_set = '{0, 0, 54, 21};
    sel_set   = '{1'b0, 1'b1, 1'b0, 1'b1};
    sel_q = 1'b1;
    clear_event();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out of range, full words on either layer, empty word
    add_row(60, 20'hFFFFF, 1, 4'b0000, 1, '0);
    add_row(63, 20'hFFFFF, 0, 4'b1111, 0, '0);
    add_row(0, 20'hFFFFF, 1, 4'b0000, 1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 9'd20, 10'd0});
    add_row(59, 20'hFFFFF, 1, 4'b0000, 1, '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 9'd0, 10'd20});
    add_row(19, 20'h00001, 0, 4'b0000, 0, '0);
    add_row(20, 20'h80000, 1, 4'b0000, 1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 9'd1, 10'd1});
    add_row(5, 20'h00000, 1, 4'b0000, 1, '0);
    // first coincidence term
    add_row(0, 20'h00001, 0, 4'b0000, 0, '0);
    add_row(10, 20'h00002, 0, 4'b0000, 0, '0);
    add_row(20, 20'h00004, 0, 4'b0000, 0, '0);
    add_row(40, 20'h00008, 1, 4'b0000, 1, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 9'd2, 10'd2});
    // wrap-around term with a repeated group, then one veto input each
    add_row(9, 20'hFFFFF, 0, 4'b0000, 0, '0);
    add_row(19, 20'hFFFFF, 0, 4'b0000, 0, '0);
    add_row(39, 20'hFFFFF, 0, 4'b0000, 0, '0);
    add_row(59, 20'hFFFFF, 0, 4'b0000, 0, '0);
    add_row(9, 20'hFFFFF, 1, 4'b1000, 0, '0);
    add_row(1, 20'h55555, 0, 4'b0000, 0, '0);
    add_row(11, 20'hAAAAA, 0, 4'b0000, 0, '0);
    add_row(22, 20'hFFFFF, 0, 4'b0000, 0, '0);
    add_row(43, 20'h00010, 1, 4'b0100, 0, '0);
    add_row(2, 20'h00100, 0, 4'b0000, 0, '0);
    add_row(12, 20'h01000, 0, 4'b0000, 0, '0);
    add_row(23, 20'h10000, 0, 4'b0000, 0, '0);
    add_row(44, 20'h00400, 1, 4'b0010, 0, '0);
    add_row(61, 20'h12345, 1, 4'b0001, 0, '0);
    foreach (script_q[r]) send_word(script_q[r].w, script_q[r].typed, script_q[r].want);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_selection(sel_set[ph]);
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      run_events(PHASE_WORDS);
    end
    drain();

    $display("run covered %0d group words and %0d decision words in four phases",
             n_words, n_decisions);
    $display("%0d decisions had topology, %0d accepted, %0d with a saturated count",
             n_topo, n_accept, n_sat);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
